[rtl/anbx_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anbx_pkg
// Shared types and constants of the Annex B NAL splitter with
// parameter-set capture.
// ----------------------------------------------------------------------------
package anbx_pkg;

    localparam int SLOT_BYTES    = 256;
    localparam int CHANNELS      = 2;
    localparam int SETS_PER_CHAN = 3;
    localparam int NSLOTS        = CHANNELS * SETS_PER_CHAN;

    localparam int SLOT_AW     = $clog2(SLOT_BYTES);
    localparam int IDX_W       = $clog2(NSLOTS);
    localparam int CAP_W       = $clog2(NSLOTS + 1);
    localparam int STORE_DEPTH = NSLOTS * SLOT_BYTES;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int OFF_W       = $clog2(SLOT_BYTES + 5);
    localparam int LEN_W       = 9;
    localparam int TYPE_W      = 6;

    // Item kinds.
    localparam logic FUNC_STREAM = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    // Codec selection.
    localparam logic CODEC_H264 = 1'b0;
    localparam logic CODEC_H265 = 1'b1;

    // Parameter-set slots within a channel.
    localparam logic [1:0] SET_VPS  = 2'd0;
    localparam logic [1:0] SET_SPS  = 2'd1;
    localparam logic [1:0] SET_PPS  = 2'd2;
    localparam logic [1:0] SET_NONE = 2'd3;

    localparam logic [7:0] H264_TYPE_MASK = 8'b0001_1111;
    localparam logic [7:0] H265_TYPE_MASK = 8'b0111_1110;
    localparam logic [7:0] START_BYTE     = 8'h01;

    localparam logic [TYPE_W-1:0] H264_SPS = 6'd7;
    localparam logic [TYPE_W-1:0] H264_PPS = 6'd8;
    localparam logic [TYPE_W-1:0] H265_VPS = 6'd32;
    localparam logic [TYPE_W-1:0] H265_SPS = 6'd33;
    localparam logic [TYPE_W-1:0] H265_PPS = 6'd34;

    typedef struct packed {
        logic       func;
        logic       chan;
        logic [7:0] data_byte;
        logic       frame_last;
        logic [1:0] set_select;
        logic [7:0] read_index;
    } item_t;

    typedef struct packed {
        logic              nal_header;
        logic [TYPE_W-1:0] nal_type;
        logic              capturing;
        logic              chan_ready;
        logic              slot_full;
        logic [LEN_W-1:0]  slot_length;
        logic              truncated;
        logic              rd_hit;
    } result_t;

    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] waddr;
        logic [7:0]          wdata;
        logic                re;
        logic [STORE_AW-1:0] raddr;
    } store_req_t;

endpackage

[rtl/anbx_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anbx_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is issued.
// ----------------------------------------------------------------------------
module anbx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/anbx_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anbx_core
// Start code parser and capture bookkeeping. Processes one item per fire,
// updates the parse and slot state and issues store writes and reads.
// ----------------------------------------------------------------------------
module anbx_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                codec_mode,
    input  logic                fire,
    input  anbx_pkg::item_t     item,
    output anbx_pkg::result_t   res,
    output anbx_pkg::store_req_t store
);
    import anbx_pkg::*;

    logic [23:0]       window_reg, window_next;
    logic [1:0]        fill_reg, fill_next;
    logic              in_nal_reg, in_nal_next;
    logic              expect_reg, expect_next;
    logic [TYPE_W-1:0] type_reg, type_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [LEN_W-1:0]  len_reg [NSLOTS];
    logic [LEN_W-1:0]  len_next [NSLOTS];
    logic [NSLOTS-1:0] valid_reg, valid_next;
    logic [NSLOTS-1:0] ovf_reg, ovf_next;
    logic [CHANNELS-1:0] ready_reg, ready_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            fill_reg   <= '0;
            in_nal_reg <= 1'b0;
            expect_reg <= 1'b0;
            type_reg   <= '0;
            cap_reg    <= '0;
            off_reg    <= '0;
            valid_reg  <= '0;
            ovf_reg    <= '0;
            ready_reg  <= '0;
            for (int i = 0; i < NSLOTS; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            window_reg <= window_next;
            fill_reg   <= fill_next;
            in_nal_reg <= in_nal_next;
            expect_reg <= expect_next;
            type_reg   <= type_next;
            cap_reg    <= cap_next;
            off_reg    <= off_next;
            valid_reg  <= valid_next;
            ovf_reg    <= ovf_next;
            ready_reg  <= ready_next;
            for (int i = 0; i < NSLOTS; i++)
            begin
                len_reg[i] <= len_next[i];
            end
        end
    end

    always_comb
    begin
        logic              chan_ok;
        logic [IDX_W-1:0]  base;
        logic [IDX_W-1:0]  rd_slot;
        logic [TYPE_W-1:0] hdr_t;
        logic [1:0]        set_code;
        logic [IDX_W-1:0]  hdr_slot;
        logic              start;
        logic [1:0]        trim;
        logic [CAP_W-1:0]  cap_cur;
        logic [OFF_W-1:0]  off_cur;
        logic              in_nal_cur;
        logic              do_store;
        logic              end_ev;
        logic              cap_end;
        logic [IDX_W-1:0]  cap_idx;
        logic [OFF_W-1:0]  diff;
        logic              hit;
        logic              sets_ok;

        window_next = window_reg;
        fill_next   = fill_reg;
        in_nal_next = in_nal_reg;
        expect_next = expect_reg;
        type_next   = type_reg;
        cap_next    = cap_reg;
        off_next    = off_reg;
        valid_next  = valid_reg;
        ovf_next    = ovf_reg;
        ready_next  = ready_reg;
        for (int i = 0; i < NSLOTS; i++)
        begin
            len_next[i] = len_reg[i];
        end
        res   = '0;
        store = '0;

        chan_ok    = int'(item.chan) < CHANNELS;
        base       = IDX_W'(int'(item.chan) * SETS_PER_CHAN);
        rd_slot    = base + IDX_W'(item.set_select);
        hdr_t      = '0;
        set_code   = SET_NONE;
        hdr_slot   = '0;
        start      = 1'b0;
        trim       = '0;
        cap_cur    = cap_reg;
        off_cur    = off_reg;
        in_nal_cur = in_nal_reg;
        do_store   = 1'b0;
        end_ev     = 1'b0;
        cap_end    = 1'b0;
        cap_idx    = IDX_W'(cap_reg - CAP_W'(1));
        diff       = '0;
        hit        = 1'b0;
        sets_ok    = 1'b0;

        if (item.func == FUNC_READ)
        begin
            if (chan_ok && item.set_select != SET_NONE)
            begin
                if (valid_reg[rd_slot])
                begin
                    res.slot_full   = 1'b1;
                    res.slot_length = len_reg[rd_slot];
                    if (LEN_W'(item.read_index) < len_reg[rd_slot]
                        && int'(item.read_index) < SLOT_BYTES)
                    begin
                        res.rd_hit  = 1'b1;
                        store.re    = 1'b1;
                        store.raddr = STORE_AW'({rd_slot,
                                                 item.read_index[SLOT_AW-1:0]});
                    end
                end
                res.truncated = ovf_reg[rd_slot];
            end
        end
        else
        begin
            if (expect_reg)
            begin
                if (codec_mode == CODEC_H264)
                begin
                    hdr_t = TYPE_W'(item.data_byte & H264_TYPE_MASK);
                    if (hdr_t == H264_SPS)
                    begin
                        set_code = SET_SPS;
                    end
                    else if (hdr_t == H264_PPS)
                    begin
                        set_code = SET_PPS;
                    end
                end
                else
                begin
                    hdr_t = TYPE_W'((item.data_byte & H265_TYPE_MASK) >> 1);
                    if (hdr_t == H265_VPS)
                    begin
                        set_code = SET_VPS;
                    end
                    else if (hdr_t == H265_SPS)
                    begin
                        set_code = SET_SPS;
                    end
                    else if (hdr_t == H265_PPS)
                    begin
                        set_code = SET_PPS;
                    end
                end
                hdr_slot    = base + IDX_W'(set_code);
                expect_next = 1'b0;
                in_nal_cur  = 1'b1;
                type_next   = hdr_t;
                off_cur     = '0;
                if (set_code != SET_NONE && chan_ok && !valid_reg[hdr_slot])
                begin
                    cap_cur = CAP_W'(hdr_slot) + CAP_W'(1);
                end
                else
                begin
                    cap_cur = '0;
                end
                do_store       = 1'b1;
                res.nal_header = 1'b1;
                res.nal_type   = hdr_t;
            end
            else
            begin
                // A start code needs two zero bytes in the window and a 0x01
                // that is not the last byte of the frame.
                start = item.data_byte == START_BYTE && !item.frame_last
                        && fill_reg >= 2'd2 && window_reg[15:0] == 16'h0000;
                if (start)
                begin
                    if (in_nal_reg)
                    begin
                        end_ev = 1'b1;
                        trim   = (fill_reg == 2'd3 && window_reg == 24'h0) ? 2'd3
                                                                            : 2'd2;
                    end
                    in_nal_cur  = 1'b0;
                    expect_next = 1'b1;
                    window_next = '0;
                    fill_next   = '0;
                end
                else
                begin
                    window_next = {window_reg[15:0], item.data_byte};
                    if (fill_reg != 2'd3)
                    begin
                        fill_next = fill_reg + 2'd1;
                    end
                    if (in_nal_reg)
                    begin
                        do_store     = 1'b1;
                        res.nal_type = type_reg;
                    end
                end
            end

            cap_idx = IDX_W'(cap_cur - CAP_W'(1));
            if (do_store && cap_cur != '0)
            begin
                if (int'(off_cur) < SLOT_BYTES)
                begin
                    store.we      = 1'b1;
                    store.waddr   = STORE_AW'({cap_idx, off_cur[SLOT_AW-1:0]});
                    store.wdata   = item.data_byte;
                    off_cur       = off_cur + OFF_W'(1);
                    res.capturing = 1'b1;
                end
                else
                begin
                    if (int'(off_cur) < SLOT_BYTES + 4)
                    begin
                        off_cur = off_cur + OFF_W'(1);
                    end
                    res.truncated = 1'b1;
                end
            end

            if (item.frame_last && in_nal_cur)
            begin
                end_ev = 1'b1;
                trim   = '0;
            end

            if (end_ev)
            begin
                if (cap_cur != '0)
                begin
                    cap_end = 1'b1;
                    diff = (off_cur >= OFF_W'(trim)) ? off_cur - OFF_W'(trim) : '0;
                    if (int'(diff) > SLOT_BYTES)
                    begin
                        len_next[cap_idx] = LEN_W'(SLOT_BYTES);
                        ovf_next[cap_idx] = 1'b1;
                    end
                    else
                    begin
                        len_next[cap_idx] = LEN_W'(diff);
                    end
                    valid_next[cap_idx] = 1'b1;
                end
                for (int c = 0; c < CHANNELS; c++)
                begin
                    hit = (chan_ok && int'(item.chan) == c)
                          || (cap_end && int'(cap_idx) >= c * SETS_PER_CHAN
                              && int'(cap_idx) < (c + 1) * SETS_PER_CHAN);
                    if (codec_mode == CODEC_H264)
                    begin
                        sets_ok = valid_next[c * SETS_PER_CHAN + int'(SET_SPS)]
                                  && valid_next[c * SETS_PER_CHAN + int'(SET_PPS)];
                    end
                    else
                    begin
                        sets_ok = valid_next[c * SETS_PER_CHAN + int'(SET_VPS)]
                                  && valid_next[c * SETS_PER_CHAN + int'(SET_SPS)]
                                  && valid_next[c * SETS_PER_CHAN + int'(SET_PPS)];
                    end
                    if (hit && sets_ok)
                    begin
                        ready_next[c] = 1'b1;
                    end
                end
                cap_cur    = '0;
                off_cur    = '0;
                in_nal_cur = 1'b0;
            end

            if (item.frame_last)
            begin
                in_nal_cur  = 1'b0;
                expect_next = 1'b0;
                window_next = '0;
                fill_next   = '0;
                cap_cur     = '0;
                off_cur     = '0;
            end

            cap_next    = cap_cur;
            off_next    = off_cur;
            in_nal_next = in_nal_cur;
        end

        res.chan_ready = chan_ok && ready_next[item.chan];
    end

endmodule

[rtl/annexb_nal_splitter_param_capture_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_nal_splitter_param_capture_unit
// Splits an Annex B byte stream at start codes, reports NAL headers and
// types, and keeps the first VPS/SPS/PPS of each channel for read-back.
//
//   Channel | Signals                                     | Direction
//   --------+---------------------------------------------+----------
//   input   | in_valid, in_stall, func, chan, data_byte,  | in
//           | frame_last, set_select, read_index          |
//   output  | out_valid, out_stall, nal_header, nal_type, | out
//           | capturing, chan_ready, slot_full,           |
//           | slot_length, read_byte, truncated           |
//   config  | cfg_valid, cfg_ready, cfg_data (codec_mode) | in
//
// One item is accepted per cycle while in_stall is low. Each result passes
// through the registers in order: the input register holds the item, the parse stage
// registers its result and issues the store access, and the output register
// picks up the registered store read.
// Reset clears all parse state, slot flags and ready flags; the byte store
// itself is not cleared. A stall on the output holds the pipeline, and
// in_stall rises only when every stage is occupied.
// ----------------------------------------------------------------------------
module annexb_nal_splitter_param_capture_unit (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic                          chan,
    input  logic [7:0]                    data_byte,
    input  logic                          frame_last,
    input  logic [1:0]                    set_select,
    input  logic [7:0]                    read_index,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          nal_header,
    output logic [anbx_pkg::TYPE_W-1:0]   nal_type,
    output logic                          capturing,
    output logic                          chan_ready,
    output logic                          slot_full,
    output logic [anbx_pkg::LEN_W-1:0]    slot_length,
    output logic [7:0]                    read_byte,
    output logic                          truncated,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data
);
    import anbx_pkg::*;

    logic       codec_mode_reg;
    logic       s0_valid_reg;
    item_t      s0_item_reg;
    logic       s1_valid_reg;
    result_t    s1_res_reg;
    logic       out_valid_reg;
    result_t    out_res_reg;
    logic [7:0] out_byte_reg;

    logic       out_adv;
    logic       s1_free;
    logic       s0_fire;
    logic       in_take;
    result_t    core_res;
    store_req_t store;
    logic [7:0] ram_rdata;

    assign cfg_ready = 1'b1;
    assign out_adv   = !out_valid_reg || !out_stall;
    assign s1_free   = !s1_valid_reg || out_adv;
    assign s0_fire   = s0_valid_reg && s1_free;
    assign in_stall  = s0_valid_reg && !s0_fire;
    assign in_take   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codec_mode_reg <= CODEC_H264;
            s0_valid_reg   <= 1'b0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                codec_mode_reg <= cfg_data;
            end
            if (in_take)
            begin
                s0_valid_reg <= 1'b1;
            end
            else if (s0_fire)
            begin
                s0_valid_reg <= 1'b0;
            end
            if (s0_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_valid_reg && out_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s0_item_reg <= '{func:       func,
                             chan:       chan,
                             data_byte:  data_byte,
                             frame_last: frame_last,
                             set_select: set_select,
                             read_index: read_index};
        end
        if (s0_fire)
        begin
            s1_res_reg <= core_res;
        end
        if (s1_valid_reg && out_adv)
        begin
            // The store read issued by the parse stage lands here.
            out_res_reg  <= s1_res_reg;
            out_byte_reg <= s1_res_reg.rd_hit ? ram_rdata : 8'h00;
        end
    end

    anbx_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .codec_mode (codec_mode_reg),
        .fire       (s0_fire),
        .item       (s0_item_reg),
        .res        (core_res),
        .store      (store)
    );

    anbx_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (store.we && s0_fire),
        .waddr (store.waddr),
        .wdata (store.wdata),
        .re    (store.re && s0_fire),
        .raddr (store.raddr),
        .rdata (ram_rdata)
    );

    assign out_valid   = out_valid_reg;
    assign nal_header  = out_res_reg.nal_header;
    assign nal_type    = out_res_reg.nal_type;
    assign capturing   = out_res_reg.capturing;
    assign chan_ready  = out_res_reg.chan_ready;
    assign slot_full   = out_res_reg.slot_full;
    assign slot_length = out_res_reg.slot_length;
    assign read_byte   = out_byte_reg;
    assign truncated   = out_res_reg.truncated;

endmodule

[test/annexb_nal_splitter_param_capture_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_nal_splitter_param_capture_unit_tb
// Self-checking bench for the Annex B NAL splitter. A short table of
// hand-picked items comes first. Random frames follow: start codes, NAL
// headers, parameter sets and read-backs, under both codec settings. Every
// result is compared field by field, typed table rows with their own value,
// all others with an in-bench model of the parser and the parameter-set store.
// ----------------------------------------------------------------------------
module annexb_nal_splitter_param_capture_unit_tb;

    import anbx_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 220;
    localparam int PHASES       = 5;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic              nal_header;
        logic [TYPE_W-1:0] nal_type;
        logic              capturing;
        logic              chan_ready;
        logic              slot_full;
        logic [LEN_W-1:0]  slot_length;
        logic [7:0]        read_byte;
        logic              truncated;
    } nal_result_t;

    typedef enum logic {ROW_ITEM, ROW_CODEC} row_kind_e;

    typedef struct {
        row_kind_e   kind;
        logic        codec;
        item_t       stim;
        bit          typed;
        nal_result_t want;
    } plan_row_t;

    localparam nal_result_t NO_RESULT = '0;

    logic                 clk;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic                 func       = FUNC_STREAM;
    logic                 chan       = 1'b0;
    logic [7:0]           data_byte  = 8'h00;
    logic                 frame_last = 1'b0;
    logic [1:0]           set_select = SET_VPS;
    logic [7:0]           read_index = 8'h00;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic                 nal_header;
    logic [TYPE_W-1:0]    nal_type;
    logic                 capturing;
    logic                 chan_ready;
    logic                 slot_full;
    logic [LEN_W-1:0]     slot_length;
    logic [7:0]           read_byte;
    logic                 truncated;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_data   = CODEC_H264;

    // Model state of the parser and the parameter-set store.
    logic                 codec_q    = CODEC_H264;
    logic [23:0]          win_q      = '0;
    int unsigned          win_fill   = 0;
    bit                   nal_open   = 1'b0;
    bit                   hdr_next   = 1'b0;
    logic [TYPE_W-1:0]    cur_type   = '0;
    int unsigned          cap_slot   = 0;
    int unsigned          cap_off    = 0;
    int unsigned          slot_len [NSLOTS];
    bit                   slot_ok  [NSLOTS];
    bit                   slot_ovf [NSLOTS];
    bit                   chan_rdy [CHANNELS];
    logic [7:0]           ps_mem   [STORE_DEPTH];

    nal_result_t          pending_results[$];
    int                   errors       = 0;
    int                   results_seen = 0;
    int                   items_sent   = 0;
    int                   bytes_sent   = 0;
    int                   reads_sent   = 0;
    int                   frames_sent  = 0;
    int                   codec_writes = 0;
    bit                   quiet        = 1'b0;
    bit                   long_forced  = 1'b0;
    int unsigned          stall_left;
    int unsigned          idle_cycles;

    annexb_nal_splitter_param_capture_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .chan        (chan),
        .data_byte   (data_byte),
        .frame_last  (frame_last),
        .set_select  (set_select),
        .read_index  (read_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .nal_header  (nal_header),
        .nal_type    (nal_type),
        .capturing   (capturing),
        .chan_ready  (chan_ready),
        .slot_full   (slot_full),
        .slot_length (slot_length),
        .read_byte   (read_byte),
        .truncated   (truncated),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Model of the splitter
    // ------------------------------------------------------------------------
    function automatic void refresh_ready(input int unsigned ch);
        int unsigned b;
        b = ch * SETS_PER_CHAN;
        if (codec_q == CODEC_H264)
        begin
            if (slot_ok[b + SET_SPS] && slot_ok[b + SET_PPS])
                chan_rdy[ch] = 1'b1;
        end
        else if (slot_ok[b + SET_VPS] && slot_ok[b + SET_SPS] && slot_ok[b + SET_PPS])
        begin
            chan_rdy[ch] = 1'b1;
        end
    endfunction

    // The zeros of a start code were stored with the NAL, so they are trimmed.
    function automatic void close_nal(input int unsigned trim, input int unsigned ch);
        int unsigned s;
        int unsigned len;
        if (cap_slot != 0)
        begin
            s   = cap_slot - 1;
            len = (cap_off >= trim) ? cap_off - trim : 0;
            if (len > SLOT_BYTES)
            begin
                len         = SLOT_BYTES;
                slot_ovf[s] = 1'b1;
            end
            slot_len[s] = len;
            slot_ok[s]  = 1'b1;
            refresh_ready(s / SETS_PER_CHAN);
        end
        refresh_ready(ch);
        cap_slot = 0;
        cap_off  = 0;
        nal_open = 1'b0;
    endfunction

    // 1: byte stored, 0: slot already full, -1: nothing is being captured.
    function automatic int keep_byte(input logic [7:0] b);
        if (cap_slot == 0)
            return -1;
        if (cap_off < SLOT_BYTES)
        begin
            ps_mem[(cap_slot - 1) * SLOT_BYTES + cap_off] = b;
            cap_off++;
            return 1;
        end
        if (cap_off < SLOT_BYTES + 4)
            cap_off++;
        return 0;
    endfunction

    function automatic nal_result_t split_and_capture(input item_t it);
        nal_result_t       r;
        int unsigned       s;
        int unsigned       ch;
        int unsigned       zeros;
        int                w;
        logic [1:0]        set_idx;
        logic [TYPE_W-1:0] t;
        bit                sc;
        r  = '0;
        ch = int'(it.chan);
        if (it.func == FUNC_READ)
        begin
            if (it.set_select != SET_NONE)
            begin
                s = ch * SETS_PER_CHAN + int'(it.set_select);
                if (slot_ok[s])
                begin
                    r.slot_full   = 1'b1;
                    r.slot_length = LEN_W'(slot_len[s]);
                    if (int'(it.read_index) < slot_len[s])
                        r.read_byte = ps_mem[s * SLOT_BYTES + int'(it.read_index)];
                end
                r.truncated = slot_ovf[s];
            end
        end
        else if (hdr_next)
        begin
            hdr_next = 1'b0;
            nal_open = 1'b1;
            set_idx  = SET_NONE;
            if (codec_q == CODEC_H264)
            begin
                t = TYPE_W'(it.data_byte & H264_TYPE_MASK);
                if (t == H264_SPS)
                    set_idx = SET_SPS;
                else if (t == H264_PPS)
                    set_idx = SET_PPS;
            end
            else
            begin
                t = TYPE_W'((it.data_byte & H265_TYPE_MASK) >> 1);
                if (t == H265_VPS)
                    set_idx = SET_VPS;
                else if (t == H265_SPS)
                    set_idx = SET_SPS;
                else if (t == H265_PPS)
                    set_idx = SET_PPS;
            end
            cur_type = t;
            cap_slot = 0;
            cap_off  = 0;
            if (set_idx != SET_NONE && !slot_ok[ch * SETS_PER_CHAN + int'(set_idx)])
                cap_slot = ch * SETS_PER_CHAN + int'(set_idx) + 1;
            w            = keep_byte(it.data_byte);
            r.nal_header = 1'b1;
            r.nal_type   = t;
            r.capturing  = (w == 1);
            r.truncated  = (w == 0);
        end
        else
        begin
            sc = (it.data_byte == START_BYTE) && !it.frame_last && win_fill >= 2 &&
                 win_q[15:0] == 16'h0000;
            if (sc)
            begin
                zeros = (win_fill == 3 && win_q == 24'h000000) ? 3 : 2;
                if (nal_open)
                    close_nal(zeros, ch);
                nal_open = 1'b0;
                hdr_next = 1'b1;
                win_q    = '0;
                win_fill = 0;
            end
            else
            begin
                win_q = {win_q[15:0], it.data_byte};
                if (win_fill < 3)
                    win_fill++;
                if (nal_open)
                begin
                    w           = keep_byte(it.data_byte);
                    r.nal_type  = cur_type;
                    r.capturing = (w == 1);
                    r.truncated = (w == 0);
                end
            end
        end
        if (it.func == FUNC_STREAM && it.frame_last)
        begin
            if (nal_open)
                close_nal(0, ch);
            nal_open = 1'b0;
            hdr_next = 1'b0;
            win_q    = '0;
            win_fill = 0;
            cap_slot = 0;
            cap_off  = 0;
        end
        r.chan_ready = chan_rdy[ch];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------------
    function automatic item_t stream_item(input logic ch, input logic [7:0] b,
                                          input logic last);
        return '{FUNC_STREAM, ch, b, last, 2'($urandom), 8'($urandom)};
    endfunction

    function automatic item_t read_item(input logic ch, input logic [1:0] sel,
                                        input logic [7:0] idx);
        return '{FUNC_READ, ch, 8'($urandom), 1'($urandom), sel, idx};
    endfunction

    // Payload bytes lean toward zero and 0x01 so start codes show up unplanned.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 7))
            0, 1, 2: return 8'h00;
            3:       return START_BYTE;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] header_for(input logic [1:0] set_pick);
        logic [7:0] h;
        h = 8'($urandom);
        if (set_pick == SET_NONE)
            return h;
        if (codec_q == CODEC_H264)
            h[4:0] = (set_pick == SET_SPS) ? H264_SPS[4:0] : H264_PPS[4:0];
        else
            h[6:1] = (set_pick == SET_VPS) ? H265_VPS :
                     (set_pick == SET_SPS) ? H265_SPS : H265_PPS;
        return h;
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    task automatic push_item(input item_t it, input bit typed, input nal_result_t typed_want);
        nal_result_t predicted;
        in_valid   <= 1'b1;
        func       <= it.func;
        chan       <= it.chan;
        data_byte  <= it.data_byte;
        frame_last <= it.frame_last;
        set_select <= it.set_select;
        read_index <= it.read_index;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predicted = split_and_capture(it);
        pending_results.push_back(typed ? typed_want : predicted);
        items_sent++;
        if (it.func == FUNC_READ)
            reads_sent++;
        else
            bytes_sent++;
    endtask

    task automatic feed(input item_t it, input bit typed, input nal_result_t typed_want);
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        push_item(it, typed, typed_want);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_codec(input logic mode);
        settle();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        codec_q = mode;
        codec_writes++;
    endtask

    task automatic send_frame(input logic ch);
        logic [7:0]  frame_bytes[$];
        logic [1:0]  set_pick;
        logic        item_chan;
        int unsigned plen;
        if ($urandom_range(0, 6) == 0)
        begin
            // A broken frame: zeros, 0x01 and random bytes with no structure.
            repeat ($urandom_range(1, 12)) frame_bytes.push_back(noise_byte());
        end
        else
        begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) frame_bytes.push_back(noise_byte());
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 1) == 1)
                    frame_bytes.push_back(8'h00);
                frame_bytes.push_back(8'h00);
                frame_bytes.push_back(8'h00);
                frame_bytes.push_back(START_BYTE);
                if ($urandom_range(0, 1) == 1)
                    set_pick = SET_NONE;
                else if (codec_q == CODEC_H264)
                    set_pick = ($urandom_range(0, 1) == 1) ? SET_SPS : SET_PPS;
                else
                    set_pick = 2'($urandom_range(0, 2));
                frame_bytes.push_back(header_for(set_pick));
                plen = $urandom_range(0, 24);
                // A set that is still open gets captured; make some of them overlong.
                if (set_pick != SET_NONE &&
                    !slot_ok[int'(ch) * SETS_PER_CHAN + int'(set_pick)] &&
                    (!long_forced || $urandom_range(0, 3) == 0))
                begin
                    plen        = $urandom_range(SLOT_BYTES - 6, SLOT_BYTES + 44);
                    long_forced = 1'b1;
                end
                repeat (plen) frame_bytes.push_back(noise_byte());
            end
            // A start code on the final byte of a frame is plain data.
            if ($urandom_range(0, 9) == 0)
            begin
                frame_bytes.push_back(8'h00);
                frame_bytes.push_back(8'h00);
                frame_bytes.push_back(START_BYTE);
            end
        end
        foreach (frame_bytes[i])
        begin
            if ($urandom_range(0, 5) == 0)
                feed(read_item(1'($urandom), 2'($urandom_range(0, 3)),
                               ($urandom_range(0, 1) == 1) ? 8'($urandom) :
                                                             8'($urandom_range(0, 15))),
                     1'b0, NO_RESULT);
            item_chan = ($urandom_range(0, 19) == 0) ? ~ch : ch;
            feed(stream_item(item_chan, frame_bytes[i], i == frame_bytes.size() - 1),
                 1'b0, NO_RESULT);
        end
        frames_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 13);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    task automatic check_field(input string what, input logic [8:0] want,
                               input logic [8:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        nal_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result arrived with no item outstanding, expected none, got type %0d",
                         $time, nal_type);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("nal_header", 9'(want.nal_header), 9'(nal_header));
                check_field("nal_type", 9'(want.nal_type), 9'(nal_type));
                check_field("capturing", 9'(want.capturing), 9'(capturing));
                check_field("chan_ready", 9'(want.chan_ready), 9'(chan_ready));
                check_field("slot_full", 9'(want.slot_full), 9'(slot_full));
                check_field("slot_length", want.slot_length, slot_length);
                check_field("read_byte", 9'(want.read_byte), 9'(read_byte));
                check_field("truncated", 9'(want.truncated), 9'(truncated));
            end
        end
    end

    // Ends the run when no handshake of any kind happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, pending_results.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        plan_row_t plan[$];
        int        goal;
        int        saturated;
        bit        paused;

        paused    = 1'b0;
        saturated = 0;

        // H.264: reads before anything is stored, a 4-byte start code and an
        // SPS, a 3-byte start code and a PPS whose frame ends on a 0x01 byte.
        plan.push_back('{ROW_ITEM, 1'b0, read_item(1'b0, SET_SPS, 8'd0), 1'b1, NO_RESULT});
        plan.push_back('{ROW_ITEM, 1'b0, read_item(1'b1, SET_NONE, 8'd255), 1'b1, NO_RESULT});
        plan.push_back('{ROW_ITEM, 1'b0, stream_item(1'b0, 8'h00, 1'b0), 1'b1, NO_RESULT});
        plan.push_back('{ROW_ITEM, 1'b0, stream_item(1'b0, 8'h00, 1'b0), 1'b1, NO_RESULT});
        plan.push_back('{ROW_ITEM, 1'b0, stream_item(1'b0, 8'h00, 1'b0), 1'b1, NO_RESULT});
        plan.push_back('{ROW_ITEM, 1'b0, stream_item(1'b0, START_BYTE, 1'b0), 1'b1, NO_RESULT});
        plan.push_back('{ROW_ITEM, 1'b0, stream_item(1'b0, 8'h67, 1'b0), 1'b1,
                         nal_result_t'({1'b1, H264_SPS, 1'b1, 1'b0, 1'b0, 9'd0, 8'd0, 1'b0})});
        plan.push_back('{ROW_ITEM, 1'b0, stream_item(1'b0, 8'hFF, 1'b0), 1'b0, NO_RESULT});
        plan.push_back('{ROW_ITEM, 1'b0, stream_item(1'b0, 8'h00, 1'b0), 1'b0, NO_RESULT});
        plan.push_back('{ROW_ITEM, 1'b0, stream_item(1'b0, 8'h00, 1'b0), 1'b0, NO_RESULT});
        plan.push_back('{ROW_ITEM, 1'b0, stream_item(1'b0, START_BYTE, 1'b0), 1'b1, NO_RESULT});
        plan.push_back('{ROW_ITEM, 1'b0, stream_item(1'b0, 8'hE8, 1'b0), 1'b0, NO_RESULT});
        plan.push_back('{ROW_ITEM, 1'b0, stream_item(1'b0, 8'h80, 1'b0), 1'b0, NO_RESULT});
        plan.push_back('{ROW_ITEM, 1'b0, stream_item(1'b0, START_BYTE, 1'b1), 1'b0, NO_RESULT});
        plan.push_back('{ROW_ITEM, 1'b0, read_item(1'b0, SET_SPS, 8'd1), 1'b0, NO_RESULT});
        plan.push_back('{ROW_ITEM, 1'b0, read_item(1'b0, SET_PPS, 8'd2), 1'b0, NO_RESULT});
        plan.push_back('{ROW_ITEM, 1'b0, read_item(1'b0, SET_PPS, 8'd255), 1'b0, NO_RESULT});
        // H.265: a VPS on the other channel, read back after its frame closes.
        plan.push_back('{ROW_CODEC, CODEC_H265, stream_item(1'b0, 8'h00, 1'b0), 1'b0, NO_RESULT});
        plan.push_back('{ROW_ITEM, 1'b0, stream_item(1'b1, 8'h00, 1'b0), 1'b0, NO_RESULT});
        plan.push_back('{ROW_ITEM, 1'b0, stream_item(1'b1, 8'h00, 1'b0), 1'b0, NO_RESULT});
        plan.push_back('{ROW_ITEM, 1'b0, stream_item(1'b1, START_BYTE, 1'b0), 1'b0, NO_RESULT});
        plan.push_back('{ROW_ITEM, 1'b0, stream_item(1'b1, 8'h40, 1'b0), 1'b0, NO_RESULT});
        plan.push_back('{ROW_ITEM, 1'b0, stream_item(1'b1, START_BYTE, 1'b1), 1'b0, NO_RESULT});
        plan.push_back('{ROW_ITEM, 1'b0, read_item(1'b1, SET_VPS, 8'd0), 1'b0, NO_RESULT});
        plan.push_back('{ROW_ITEM, 1'b0, read_item(1'b1, SET_SPS, 8'd0), 1'b0, NO_RESULT});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CODEC)
                write_codec(plan[i].codec);
            else
                feed(plan[i].stim, plan[i].typed, plan[i].want);
        end

        // Alternate the codec; the last phase runs without any idling.
        for (int p = 0; p < PHASES; p++)
        begin
            write_codec((p % 2 == 0) ? CODEC_H264 : CODEC_H265);
            quiet = (p == PHASES - 1);
            goal  = items_sent + PHASE_ITEMS;
            while (items_sent < goal)
            begin
                send_frame(1'($urandom));
                if (p == 2 && !paused && items_sent > goal - PHASE_ITEMS / 2)
                begin
                    settle();
                    paused = 1'b1;
                end
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        foreach (slot_ovf[i])
            saturated += int'(slot_ovf[i]);
        $display("Sent %0d stream bytes and %0d read-backs in %0d frames with %0d codec writes.",
                 bytes_sent, reads_sent, frames_sent, codec_writes);
        $display("Checked %0d results; %0d of %0d slots were saturated.",
                 results_seen, saturated, NSLOTS);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
rtl/anbx_pkg.sv
rtl/anbx_ram.sv
rtl/anbx_core.sv
rtl/annexb_nal_splitter_param_capture_unit.sv
test/annexb_nal_splitter_param_capture_unit_tb.sv
